FILE: design/boi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// boi_pkg
// Shared types, constants and helpers of the bicycle odometry integrator.
// ----------------------------------------------------------------------------
package boi_pkg;

	localparam int CDC_W  = 52;
	localparam int CDC_ZW = 34;
	localparam int MUL_W  = 35;
	localparam int DIV_STEPS = 31;

	localparam logic signed [CDC_W-1:0] CDC_X0 = 52'sd652032874;
	localparam logic signed [CDC_ZW-1:0] ANG_QTR = 34'sd1073741824;
	localparam logic signed [CDC_ZW-1:0] ANG_HALF = 34'sd2147483648;

	localparam logic [31:0] RAD_TO_BIN = 32'd2734261102;
	localparam logic [31:0] YAW_DT_K   = 32'd44798134;
	localparam logic [31:0] VAR_BASE   = 32'd6554;
	localparam logic [31:0] VAR_SLOPE  = 32'd4294967;

	localparam logic [2:0] REG_SPEED_OFFSET  = 3'd0;
	localparam logic [2:0] REG_SPEED_GAIN    = 3'd1;
	localparam logic [2:0] REG_STEER_OFFSET  = 3'd2;
	localparam logic [2:0] REG_STEER_GAIN    = 3'd3;
	localparam logic [2:0] REG_INV_WHEELBASE = 3'd4;
	localparam logic [2:0] REG_REAR_RATIO    = 3'd5;
	localparam logic [2:0] REG_TACH_GAIN     = 3'd6;

	typedef struct packed {
		logic                     start;
		logic                     vec;
		logic [31:0]              ang;
		logic signed [CDC_W-1:0]  x0;
		logic signed [CDC_W-1:0]  y0;
	} cdc_req_t;

	function automatic logic [31:0] atan_tab(input logic [4:0] i);
		case (i)
			5'd0: return 32'h20000000;
			5'd1: return 32'h12E4051E;
			5'd2: return 32'h09FB385B;
			5'd3: return 32'h051111D4;
			5'd4: return 32'h028B0D43;
			5'd5: return 32'h0145D7E1;
			5'd6: return 32'h00A2F61E;
			5'd7: return 32'h00517C55;
			5'd8: return 32'h0028BE53;
			5'd9: return 32'h00145F2F;
			5'd10: return 32'h000A2F98;
			5'd11: return 32'h000517CC;
			5'd12: return 32'h00028BE6;
			5'd13: return 32'h000145F3;
			5'd14: return 32'h0000A2FA;
			5'd15: return 32'h0000517D;
			5'd16: return 32'h000028BE;
			5'd17: return 32'h0000145F;
			5'd18: return 32'h00000A30;
			5'd19: return 32'h00000518;
			5'd20: return 32'h0000028C;
			5'd21: return 32'h00000146;
			5'd22: return 32'h000000A3;
			5'd23: return 32'h00000051;
			5'd24: return 32'h00000029;
			5'd25: return 32'h00000014;
			5'd26: return 32'h0000000A;
			5'd27: return 32'h00000005;
			5'd28: return 32'h00000003;
			5'd29: return 32'h00000001;
			5'd30: return 32'h00000001;
			default: return 32'h00000000;
		endcase
	endfunction

	function automatic logic [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'h7FFFFFFF;
		else if (v < -36'sd2147483648) return 32'h80000000;
		else return v[31:0];
	endfunction

	function automatic logic [15:0] q15(input logic signed [34:0] v);
		logic signed [35:0] r;
		r = ($signed({v[34], v}) + 36'sd16384) >>> 15;
		if (r > 36'sd32767) return 16'h7FFF;
		else if (r < -36'sd32768) return 16'h8000;
		else return r[15:0];
	endfunction

endpackage
`default_nettype wire

FILE: design/bicycle_odometry_integrator.sv
`default_nettype none
// A servo word is held in the idle state and gives no result.
// A motor word gives one result; no new word is taken until it is done.
// Most of the work is up to four passes of the shared CORDIC and the 31-step
// divider. Reset is asynchronous, active low; it clears pose and history and
// puts the configuration registers back to their defaults.
// ----------------------------------------------------------------------------
// bicycle_odometry_integrator
// Kinematic bicycle dead reckoning on one shared multiplier and CORDIC.
// ----------------------------------------------------------------------------
module bicycle_odometry_integrator #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic signed [31:0] speed_reading,
	input  logic signed [31:0] tach_count,
	input  logic [31:0]        time_us,
	input  logic [15:0]        servo_position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w,
	output logic signed [31:0] lin_speed,
	output logic signed [31:0] yaw_rate,
	output logic [31:0]        speed_variance
);
	import boi_pkg::*;

	typedef enum logic [24:0] {
		ST_IDLE = 25'h0000001, ST_MV   = 25'h0000002, ST_MD  = 25'h0000004,
		ST_MR   = 25'h0000008, ST_RD   = 25'h0000010, ST_CR1 = 25'h0000020,
		ST_BY   = 25'h0000040, ST_TM   = 25'h0000080, ST_NN  = 25'h0000100,
		ST_BETA = 25'h0000200, ST_CV   = 25'h0000400, ST_OM  = 25'h0000800,
		ST_DIV  = 25'h0001000, ST_DS   = 25'h0002000, ST_DS2 = 25'h0004000,
		ST_CR2  = 25'h0008000, ST_PX   = 25'h0010000, ST_PY  = 25'h0020000,
		ST_PP   = 25'h0040000, ST_H1   = 25'h0080000, ST_H2  = 25'h0100000,
		ST_H3   = 25'h0200000, ST_CR3  = 25'h0400000, ST_VAR = 25'h0800000,
		ST_OUT  = 25'h1000000
	} state_t;

	state_t state_q;

	logic [31:0] spd_off_q, spd_gain_q, tach_gain_q;
	logic [15:0] steer_off_q, steer_gain_q, inv_wb_q, rear_q;
	logic [31:0] acc_x_q, acc_y_q, acc_hdg_q, prev_time_q, prev_tach_q;
	logic        prev_valid_q, servo_valid_q;
	logic [15:0] servo_held_q;

	logic [31:0] spd_in_q, tach_in_q, time_in_q;
	logic signed [2*MUL_W-1:0] mul_q, mul_p;
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic        neg_q, om_neg_q;
	logic [31:0] v_q, beta_q, om_q, dt_q, p_lo_q, hi_q;
	logic [32:0] cd_q, sd_q, cm_q, rem_q;
	logic signed [48:0] bx_q, by_q;
	logic [49:0] nn_q;
	logic [30:0] quo_q, nlo_q;
	logic [4:0]  div_cnt_q;
	logic [33:0] ds_q;

	logic        out_valid_q;
	logic [31:0] pos_x_q, pos_y_q, heading_q, lin_speed_q, yaw_rate_q, var_q;
	logic [15:0] quat_z_q, quat_w_q;

	cdc_req_t    cdc_req;
	logic        cdc_run;
	logic signed [CDC_W-1:0] cdc_x, cdc_y;
	logic [31:0] cdc_z;

	logic [32:0] spd_diff, spd_mag, prod_mag, sdmag, cdmag, tdiff, tmag, ds_mag, tm;
	logic [16:0] srv_diff;
	logic [47:0] m_hi16;
	logic [31:0] v_sat, dbin, vmag, ommag, hdg_d, hdg_new;
	logic signed [48:0] by_raw, bx_raw;
	logic [33:0] div_t, div_r;
	logic        div_ge;
	logic [30:0] quo_n;
	logic signed [33:0] step;
	logic signed [35:0] acc_x_sum, acc_y_sum;
	logic        acc_in, acc_out;

	boi_cordic #(.ITERS(CORDIC_ITERATIONS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cdc_req),
		.run    (cdc_run),
		.x_out  (cdc_x),
		.y_out  (cdc_y),
		.z_out  (cdc_z)
	);

	assign acc_in  = in_valid && !in_stall;
	assign acc_out = out_valid_q && !out_stall;
	assign mul_p = mul_a * mul_b;

	always_comb begin
		spd_diff = {spd_in_q[31], spd_in_q} - {spd_off_q[31], spd_off_q};
		spd_mag = spd_diff[32] ? 33'd0 - spd_diff : spd_diff;
		m_hi16 = mul_q[63:16];
		if (neg_q) v_sat = (m_hi16 > 48'h80000000) ? 32'h80000000 : 32'(48'd0 - m_hi16);
		else v_sat = (m_hi16 > 48'h7FFFFFFF) ? 32'h7FFFFFFF : m_hi16[31:0];
		srv_diff = {1'b0, servo_held_q} - {1'b0, steer_off_q};
		prod_mag = mul_q[32] ? 33'd0 - mul_q[32:0] : mul_q[32:0];
		if (!servo_valid_q) dbin = '0;
		else if (neg_q) dbin = 32'd0 - mul_q[63:32];
		else dbin = mul_q[63:32];
		vmag = v_q[31] ? 32'd0 - v_q : v_q;
		sdmag = sd_q[32] ? 33'd0 - sd_q : sd_q;
		cdmag = cd_q[32] ? 33'd0 - cd_q : cd_q;
		by_raw = mul_q[48:0];
		bx_raw = $signed({cd_q, 16'h0000});
		tm = mul_q[62:30];
		div_t = {rem_q, nlo_q[30]};
		div_ge = div_t >= {1'b0, cm_q};
		div_r = div_ge ? div_t - {1'b0, cm_q} : div_t;
		quo_n = {quo_q[29:0], div_ge};
		tdiff = prev_valid_q ? {tach_in_q[31], tach_in_q} - {prev_tach_q[31], prev_tach_q}
			: 33'd0;
		tmag = tdiff[32] ? 33'd0 - tdiff : tdiff;
		ds_mag = (m_hi16 > 48'h100000000) ? 33'h100000000 : m_hi16[32:0];
		step = mul_q[63:30];
		acc_x_sum = $signed({{4{acc_x_q[31]}}, acc_x_q}) + $signed({{2{step[33]}}, step});
		acc_y_sum = $signed({{4{acc_y_q[31]}}, acc_y_q}) + $signed({{2{step[33]}}, step});
		ommag = om_q[31] ? 32'd0 - om_q : om_q;
		hdg_d = hi_q + mul_q[63:32];
		hdg_new = om_q[31] ? acc_hdg_q - hdg_d : acc_hdg_q + hdg_d;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MV: begin
				mul_a = $signed({2'b00, spd_mag});
				mul_b = $signed({3'b000, spd_gain_q});
			end
			ST_MD: begin
				mul_a = $signed({{18{srv_diff[16]}}, srv_diff});
				mul_b = $signed({{19{steer_gain_q[15]}}, steer_gain_q});
			end
			ST_MR: begin
				mul_a = $signed({2'b00, prod_mag});
				mul_b = $signed({3'b000, RAD_TO_BIN});
			end
			ST_BY: begin
				mul_a = $signed({19'h0, rear_q});
				mul_b = $signed({{2{sd_q[32]}}, sd_q});
			end
			ST_TM: begin
				mul_a = $signed({3'b000, vmag});
				mul_b = $signed({2'b00, sdmag});
			end
			ST_NN: begin
				mul_a = $signed({2'b00, tm});
				mul_b = $signed({19'h0, inv_wb_q});
			end
			ST_DS: begin
				mul_a = $signed({2'b00, tmag});
				mul_b = $signed({3'b000, tach_gain_q});
			end
			ST_PX: begin
				mul_a = $signed({ds_q[33], ds_q});
				mul_b = cdc_x[MUL_W-1:0];
			end
			ST_PY: begin
				mul_a = $signed({ds_q[33], ds_q});
				mul_b = cdc_y[MUL_W-1:0];
			end
			ST_PP: begin
				mul_a = $signed({3'b000, ommag});
				mul_b = $signed({3'b000, dt_q});
			end
			ST_H1: begin
				mul_a = $signed({3'b000, mul_q[63:32]});
				mul_b = $signed({3'b000, YAW_DT_K});
			end
			ST_H2: begin
				mul_a = $signed({3'b000, p_lo_q});
				mul_b = $signed({3'b000, YAW_DT_K});
			end
			ST_VAR, ST_OUT: begin
				mul_a = $signed({3'b000, vmag});
				mul_b = $signed({3'b000, VAR_SLOPE});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		cdc_req = '0;
		case (state_q)
			ST_RD: begin
				cdc_req.start = 1'b1;
				cdc_req.ang = dbin;
			end
			ST_BETA: begin
				cdc_req.start = (by_q != '0) && (bx_q != '0);
				cdc_req.vec = 1'b1;
				cdc_req.x0 = $signed({{3{bx_q[48]}}, bx_q});
				cdc_req.y0 = $signed({{3{by_q[48]}}, by_q});
			end
			ST_DS2: begin
				cdc_req.start = 1'b1;
				cdc_req.ang = acc_hdg_q + beta_q;
			end
			ST_H3: begin
				cdc_req.start = 1'b1;
				cdc_req.ang = {hdg_new[31], hdg_new[31:1]};
			end
			default: cdc_req = '0;
		endcase
	end

	// sequencer, configuration and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			spd_off_q <= '0;
			spd_gain_q <= '0;
			steer_off_q <= 16'd32768;
			steer_gain_q <= '0;
			inv_wb_q <= 16'd12412;
			rear_q <= 16'd32768;
			tach_gain_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_hdg_q <= '0;
			prev_valid_q <= 1'b0;
			prev_time_q <= '0;
			prev_tach_q <= '0;
			servo_valid_q <= 1'b0;
			servo_held_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SPEED_OFFSET: spd_off_q <= cfg_data;
					REG_SPEED_GAIN: spd_gain_q <= cfg_data;
					REG_STEER_OFFSET: steer_off_q <= cfg_data[15:0];
					REG_STEER_GAIN: steer_gain_q <= cfg_data[15:0];
					REG_INV_WHEELBASE: inv_wb_q <= cfg_data[15:0];
					REG_REAR_RATIO: rear_q <= cfg_data[15:0];
					REG_TACH_GAIN: tach_gain_q <= cfg_data;
					default: ;
				endcase
			end
			if (acc_out && state_q != ST_OUT) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc_in && !cmd) begin
						servo_held_q <= servo_position;
						servo_valid_q <= 1'b1;
					end else if (acc_in) begin
						state_q <= ST_MV;
					end
				end
				ST_MV: state_q <= ST_MD;
				ST_MD: state_q <= ST_MR;
				ST_MR: state_q <= ST_RD;
				ST_RD: state_q <= ST_CR1;
				ST_CR1: if (!cdc_run) state_q <= ST_BY;
				ST_BY: state_q <= ST_TM;
				ST_TM: state_q <= ST_NN;
				ST_NN: state_q <= ST_BETA;
				ST_BETA: state_q <= cdc_req.start ? ST_CV : ST_OM;
				ST_CV: if (!cdc_run) state_q <= ST_OM;
				ST_OM: begin
					if (nn_q == '0 || nn_q >= {4'h0, cm_q, 13'h0000}) state_q <= ST_DS;
					else state_q <= ST_DIV;
				end
				ST_DIV: if (div_cnt_q == 5'(DIV_STEPS - 1)) state_q <= ST_DS;
				ST_DS: state_q <= ST_DS2;
				ST_DS2: state_q <= ST_CR2;
				ST_CR2: if (!cdc_run) state_q <= ST_PX;
				ST_PX: state_q <= ST_PY;
				ST_PY: begin
					acc_x_q <= sat32(acc_x_sum);
					state_q <= ST_PP;
				end
				ST_PP: begin
					acc_y_q <= sat32(acc_y_sum);
					state_q <= ST_H1;
				end
				ST_H1: state_q <= ST_H2;
				ST_H2: state_q <= ST_H3;
				ST_H3: begin
					acc_hdg_q <= hdg_new;
					prev_time_q <= time_in_q;
					prev_tach_q <= tach_in_q;
					prev_valid_q <= 1'b1;
					state_q <= ST_CR3;
				end
				ST_CR3: if (!cdc_run) state_q <= ST_VAR;
				ST_VAR: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath work registers
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		case (state_q)
			ST_IDLE: begin
				spd_in_q <= speed_reading;
				tach_in_q <= tach_count;
				time_in_q <= time_us;
			end
			ST_MV: neg_q <= spd_diff[32];
			ST_MD: v_q <= v_sat;
			ST_MR: neg_q <= mul_q[32];
			ST_CR1: begin
				cd_q <= cdc_x[32:0];
				sd_q <= cdc_y[32:0];
			end
			ST_TM: begin
				by_q <= cd_q[32] ? 49'sd0 - by_raw : by_raw;
				bx_q <= cd_q[32] ? 49'sd0 - bx_raw : bx_raw;
				cm_q <= cdmag;
				om_neg_q <= v_q[31] ^ sd_q[32] ^ cd_q[32];
			end
			ST_BETA: begin
				nn_q <= mul_q[49:0];
				if (by_q == '0) beta_q <= '0;
				else if (bx_q == '0) beta_q <= by_q[48] ? 32'hC0000000 : 32'h40000000;
			end
			ST_CV: beta_q <= cdc_z;
			ST_OM: begin
				if (nn_q == '0) om_q <= '0;
				else om_q <= om_neg_q ? 32'h80000000 : 32'h7FFFFFFF;
				rem_q <= nn_q[45:13];
				nlo_q <= {nn_q[12:0], 18'h00000};
				quo_q <= '0;
				div_cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= div_r[32:0];
				quo_q <= quo_n;
				nlo_q <= {nlo_q[29:0], 1'b0};
				div_cnt_q <= div_cnt_q + 1'b1;
				om_q <= om_neg_q ? 32'd0 - {1'b0, quo_n} : {1'b0, quo_n};
			end
			ST_DS: begin
				neg_q <= tdiff[32];
				dt_q <= prev_valid_q ? time_in_q - prev_time_q : 32'd0;
			end
			ST_DS2: ds_q <= neg_q ? 34'd0 - {1'b0, ds_mag} : {1'b0, ds_mag};
			ST_H1: p_lo_q <= mul_q[31:0];
			ST_H2: hi_q <= mul_q[31:0];
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					pos_x_q <= acc_x_q;
					pos_y_q <= acc_y_q;
					heading_q <= acc_hdg_q;
					quat_z_q <= q15(cdc_y[MUL_W-1:0]);
					quat_w_q <= q15(cdc_x[MUL_W-1:0]);
					lin_speed_q <= v_q;
					yaw_rate_q <= om_q;
					var_q <= VAR_BASE + mul_q[63:32];
				end
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign heading = heading_q;
	assign quat_z = quat_z_q;
	assign quat_w = quat_w_q;
	assign lin_speed = lin_speed_q;
	assign yaw_rate = yaw_rate_q;
	assign speed_variance = var_q;

`ifndef NO_ASSERTIONS
	a_motor_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && cmd) |=> (state_q == ST_MV))
		else $error("motor word did not start the sequence");
	a_servo_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && !cmd) |=> (state_q == ST_IDLE && servo_valid_q))
		else $error("servo word left idle or was not held");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result word raised outside the output step");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < cm_q))
		else $error("divider remainder not below divisor");
	a_cordic_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !cdc_run)
		else $error("CORDIC running while idle");
`endif

endmodule
`default_nettype wire

FILE: design/boi_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// boi_cordic
// Shared CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module boi_cordic #(
	parameter int ITERS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  boi_pkg::cdc_req_t                 req,
	output logic                              run,
	output logic signed [boi_pkg::CDC_W-1:0]  x_out,
	output logic signed [boi_pkg::CDC_W-1:0]  y_out,
	output logic [31:0]                       z_out
);
	import boi_pkg::*;

	localparam int IW = (ITERS > 1) ? $clog2(ITERS) : 1;

	logic signed [CDC_W-1:0]  x_q, y_q, x_n, y_n, xs, ys;
	logic signed [CDC_ZW-1:0] z_q, z_n, za, za_adj, at;
	logic [IW-1:0]            cnt_q;
	logic                     run_q, vec_q, flip_q, flip_n, plus;

	always_comb begin
		za = $signed({{(CDC_ZW-32){req.ang[31]}}, req.ang});
		za_adj = za;
		flip_n = 1'b0;
		if (za > ANG_QTR) begin
			za_adj = za - ANG_HALF;
			flip_n = 1'b1;
		end else if (za < -ANG_QTR) begin
			za_adj = za + ANG_HALF;
			flip_n = 1'b1;
		end
	end

	always_comb begin
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		at = $signed({{(CDC_ZW-32){1'b0}}, atan_tab(5'(cnt_q))});
		plus = vec_q ? !(y_q > 0) : !z_q[CDC_ZW-1];
		if (plus) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - at;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == IW'(ITERS - 1)) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			vec_q <= req.vec;
			flip_q <= !req.vec && flip_n;
			x_q <= req.vec ? req.x0 : CDC_X0;
			y_q <= req.vec ? req.y0 : '0;
			z_q <= req.vec ? '0 : za_adj;
		end else if (run_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
	end

	assign run = run_q;
	assign x_out = flip_q ? -x_q : x_q;
	assign y_out = flip_q ? -y_q : y_q;
	assign z_out = z_q[31:0];

endmodule
`default_nettype wire
